/* rtl/bshd_pkg.sv */
// Shared types and constants for the button scan hold-off debouncer.
`default_nettype none
package bshd_pkg;

  // Field widths of the stream words
  localparam int BTN_W   = 4;
  localparam int TIME_W  = 32;
  localparam int HOLD_W  = 16;
  localparam int TDATA_W = 8;

  // Reset value of the lockout register, in milliseconds
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd100;

  // Word kinds carried on in_tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Classified command
  typedef struct packed {
    logic             is_sample;
    logic [BTN_W-1:0] button;
    logic             level;
  } cmd_t;

  // Reported change
  typedef struct packed {
    logic [BTN_W-1:0] key_index;
    logic             pressed;
  } event_t;

endpackage
`default_nettype wire

/* rtl/bshd_front.sv */
// Front end: accepts input words, classifies them and drops out-of-range samples.
`default_nettype none
module bshd_front #(
  parameter int NUM_BUTTONS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [bshd_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                       in_tuser,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output bshd_pkg::cmd_t                  push_cmd
);
  import bshd_pkg::*;

  localparam logic [BTN_W:0] NUM_BTN_L = (BTN_W+1)'(NUM_BUTTONS);

  logic             is_sample;
  logic [BTN_W-1:0] button;
  logic             in_range;
  logic             keep;

  // Decode the word
  assign is_sample = (in_tuser == OP_SAMPLE);
  assign button    = in_tdata[BTN_W-1:0];
  assign in_range  = ({1'b0, button} < NUM_BTN_L);
  assign keep      = !is_sample || in_range;

  // Accept whenever the queue has room; drop samples of absent buttons
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && keep;

  always_comb begin
    push_cmd.is_sample = is_sample;
    push_cmd.button    = button;
    push_cmd.level     = in_tdata[BTN_W];
  end

  // Clock and reset are kept for interface symmetry with the other stages
  logic unused_ok;
  assign unused_ok = clk & rst_n & (|in_tdata[TDATA_W-1:BTN_W+1]);

endmodule
`default_nettype wire

/* rtl/bshd_queue.sv */
// Short command queue that decouples the front end from the execution stage.
`default_nettype none
module bshd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire bshd_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output bshd_pkg::cmd_t      pop_cmd
);
  import bshd_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Fill count matches the pointer distance and never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

/* rtl/bshd_back.sv */
// Execution stage: time base, lockout check, key bitmap, timestamps and event register.
`default_nettype none
module bshd_back #(
  parameter int NUM_BUTTONS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bshd_pkg::HOLD_W-1:0]  cfg_wdata,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire bshd_pkg::cmd_t               q_cmd,
  output logic                              ev_valid,
  input  wire logic                         ev_ready,
  output bshd_pkg::event_t                  ev
);
  import bshd_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [TIME_W-1:0]      cnt_r, cnt_nxt;
  logic [TIME_W-1:0]      ts_r [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] key_bits_r, key_bits_nxt;
  logic [HOLD_W-1:0]      holdoff_r;
  logic                   ev_valid_r, ev_valid_nxt;
  event_t                 ev_r;

  logic              pop;
  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] age;
  logic              locked;
  logic              changed;
  logic              fire;

  // Pop a command whenever the event register is free or draining
  assign pop     = q_valid && (!ev_valid_r || ev_ready);
  assign q_ready = !ev_valid_r || ev_ready;

  // Lockout check with wrapping time difference
  assign idx     = q_cmd.button[IDX_W-1:0];
  assign age     = cnt_r - ts_r[idx];
  assign locked  = (age < {{(TIME_W-HOLD_W){1'b0}}, holdoff_r});
  assign changed = (key_bits_r[idx] != q_cmd.level);
  assign fire    = pop && q_cmd.is_sample && !locked && changed;

  always_comb begin
    cnt_nxt      = cnt_r;
    key_bits_nxt = key_bits_r;
    ev_valid_nxt = ev_valid_r;
    if (pop && !q_cmd.is_sample) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (fire) begin
      key_bits_nxt[idx] = q_cmd.level;
    end
    if (fire) begin
      ev_valid_nxt = 1'b1;
    end else if (ev_ready) begin
      ev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      key_bits_r <= '0;
      ev_valid_r <= 1'b0;
      holdoff_r  <= HOLDOFF_RESET;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        ts_r[i] <= '0;
      end
    end else begin
      cnt_r      <= cnt_nxt;
      key_bits_r <= key_bits_nxt;
      ev_valid_r <= ev_valid_nxt;
      if (cfg_we) begin
        holdoff_r <= cfg_wdata;
      end
      if (fire) begin
        ts_r[idx] <= cnt_r;
      end
    end
  end

  // Load the event payload
  always_ff @(posedge clk) begin
    if (fire) begin
      ev_r.key_index <= q_cmd.button;
      ev_r.pressed   <= q_cmd.level;
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

  // A tick advances the time base by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_cmd.is_sample) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("tick did not advance the counter");
  // Every reported event flips exactly one key bit
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ($countones(key_bits_r ^ $past(key_bits_r)) == 1))
    else $error("event without a single key change");
  // Key bits only move when an event is produced
  assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> (key_bits_r == $past(key_bits_r)))
    else $error("key bits changed without an event");
  // An event is never overwritten while it waits
  assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid_r && !ev_ready) |-> !fire)
    else $error("pending event overwritten");

endmodule
`default_nettype wire

/* rtl/button_scan_holdoff_debounce_core.sv */
// Top level of the scanned-button debouncer with per-button lockout.
//
// Takes one word per clock on the input stream while the command queue
// has room: in_tuser = 0 is a one millisecond tick, in_tuser = 1 a button
// sample. A word leaves the front end in the cycle it is accepted, is
// registered in the four-entry command queue, and is executed in the back
// stage: the wrapping 32-bit age compare against the lockout time gates the
// bitmap update, the timestamp write and the load of the event register
// that offers a change on the output stream, all made at the same edge.
// A stalled output stops the back stage only; the input keeps flowing
// until the queue is full. Timestamps reset to zero, so samples taken
// during the first lockout window after reset are ignored. Samples for
// buttons at or above NUM_BUTTONS are dropped at the input.
`default_nettype none
module button_scan_holdoff_debounce_core #(
  parameter int NUM_BUTTONS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Lockout time in milliseconds
  input  wire logic                         cfg_we,
  input  wire logic [bshd_pkg::HOLD_W-1:0]  cfg_wdata,
  // Input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [bshd_pkg::TDATA_W-1:0] in_tdata,  // [3:0] button, [4] level
  input  wire logic                         in_tuser,  // [0] op: 0 tick, 1 sample
  // Result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [bshd_pkg::TDATA_W-1:0]      out_tdata  // [3:0] key_index, [4] pressed
);
  import bshd_pkg::*;

  logic   push_valid, push_ready;
  cmd_t   push_cmd;
  logic   q_valid, q_ready;
  cmd_t   q_cmd;
  event_t ev;

  // Accept and classify
  bshd_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Buffer commands
  bshd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Execute
  bshd_back #(.NUM_BUTTONS(NUM_BUTTONS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .ev_valid  (out_tvalid),
    .ev_ready  (out_tready),
    .ev        (ev)
  );

  // Pack the result word
  assign out_tdata = {{(TDATA_W-BTN_W-1){1'b0}}, ev.pressed, ev.key_index};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the button scan hold-off debouncer.
`timescale 1ns / 100ps
module tb_top;
  import bshd_pkg::*;

  localparam int KEYS       = 16;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 140;
  localparam int DRAIN_WAIT = 10;
  localparam int STALL_MAX  = 13;
  localparam int HANG_LIMIT = 3000;
  localparam int DIR_ROWS   = 25;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;
  typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_EVENT } row_chk_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [BTN_W-1:0] btn;
    logic             lvl;
    logic [7:0]       reps;
    row_chk_t         chk;
    logic [BTN_W-1:0] key;
    logic             pr;
    logic [HOLD_W-1:0] hold;
  } row_t;

  // Directed plan, starting from the reset lockout of 100 ms
  localparam row_t PLAN [DIR_ROWS] = '{
    // start-up lockout: nothing passes before 100 ticks
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b1, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd15, 1'b1, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    // ticks with button and level set, which must be ignored
    '{ROW_WORD, OP_TICK,   4'd15, 1'b1, 8'd99, CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd3,  1'b1, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_TICK,   4'd0,  1'b0, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    // lockout just expired
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b1, 8'd1,  CHK_EVENT, 4'd0,  1'b1, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd15, 1'b1, 8'd1,  CHK_EVENT, 4'd15, 1'b1, 16'd0},
    // unchanged level, then a change inside the lockout
    '{ROW_WORD, OP_SAMPLE, 4'd5,  1'b0, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b0, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_TICK,   4'd10, 1'b0, 8'd99, CHK_MODEL, 4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b0, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_TICK,   4'd0,  1'b1, 8'd1,  CHK_MODEL, 4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b0, 8'd1,  CHK_EVENT, 4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd10, 1'b1, 8'd1,  CHK_EVENT, 4'd10, 1'b1, 16'd0},
    // zero lockout: back-to-back changes all pass
    '{ROW_CFG,  OP_TICK,   4'd0,  1'b0, 8'd0,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b1, 8'd1,  CHK_EVENT, 4'd0,  1'b1, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd0,  1'b0, 8'd1,  CHK_EVENT, 4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd6,  1'b1, 8'd1,  CHK_MODEL, 4'd0,  1'b0, 16'd0},
    // largest lockout blocks everything this early
    '{ROW_CFG,  OP_TICK,   4'd0,  1'b0, 8'd0,  CHK_NONE,  4'd0,  1'b0, 16'hFFFF},
    '{ROW_WORD, OP_SAMPLE, 4'd6,  1'b0, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_TICK,   4'd5,  1'b1, 8'd1,  CHK_MODEL, 4'd0,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd9,  1'b1, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0},
    // one millisecond lockout, exact boundary
    '{ROW_CFG,  OP_TICK,   4'd0,  1'b0, 8'd0,  CHK_NONE,  4'd0,  1'b0, 16'd1},
    '{ROW_WORD, OP_SAMPLE, 4'd6,  1'b0, 8'd1,  CHK_EVENT, 4'd6,  1'b0, 16'd0},
    '{ROW_WORD, OP_SAMPLE, 4'd6,  1'b1, 8'd1,  CHK_NONE,  4'd0,  1'b0, 16'd0}
  };

  localparam logic [HOLD_W-1:0] PHASE_HOLD [PHASES] = '{
    16'd3, 16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd2, 16'd100, 16'd15, 16'd0, 16'd5, 16'd0, 16'd2
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [HOLD_W-1:0]    cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 in_tuser   = OP_TICK;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [TDATA_W-1:0]   out_tdata;

  // Shadow state of the debouncer
  logic [TIME_W-1:0]    now_ms;
  logic [TIME_W-1:0]    change_stamp [KEYS];
  logic [KEYS-1:0]      key_levels;
  logic [HOLD_W-1:0]    lockout_ms;

  event_t               pending_events [$];
  int                   in_idle_odds;
  int                   out_stall_odds;
  int                   stall_left;
  int                   hang_cycles;
  int                   words_sent;
  int                   events_seen;
  int                   cfg_writes;
  int                   mismatches;

  button_scan_holdoff_debounce_core #(.NUM_BUTTONS(KEYS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [3:0] button, [4] level
    .in_tuser   (in_tuser),   // [0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [3:0] key_index, [4] pressed
  );

  always #5 clk = ~clk;

  // Advance the shadow state by one word; return 1 with the event it reports
  function automatic bit debounce_step(input logic op, input logic [BTN_W-1:0] btn,
                                       input logic lvl, output event_t ev);
    ev = '0;
    if (op == OP_TICK) begin
      now_ms = now_ms + 1;
      return 1'b0;
    end
    if (int'(btn) >= KEYS) return 1'b0;
    if (now_ms - change_stamp[btn] < {16'd0, lockout_ms}) return 1'b0;
    if (key_levels[btn] == lvl) return 1'b0;
    key_levels[btn]   = lvl;
    change_stamp[btn] = now_ms;
    ev.key_index      = btn;
    ev.pressed        = lvl;
    return 1'b1;
  endfunction

  // Hold the input low for a random burst now and then
  task automatic idle_burst();
    if (in_idle_odds != 0 && $urandom_range(0, in_idle_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
    end
  endtask

  // Offer one word and wait for it to be taken
  task automatic push_word(input logic op, input logic [BTN_W-1:0] btn, input logic lvl);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, lvl, btn};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Drain the block, then write the lockout register
  task automatic set_lockout(input logic [HOLD_W-1:0] hold);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we     <= 1'b0;
    lockout_ms = hold;
    cfg_writes++;
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || out_stall_odds == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, out_stall_odds - 1) == 0) begin
      stall_left <= $urandom_range(0, STALL_MAX - 1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each reported change with the oldest expected one
  always @(posedge clk) begin : check_events
    event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: key_index %0d pressed %0d", out_tdata[3:0], out_tdata[4]);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[3:0] != want.key_index) begin
          $error("key_index: expected %0d, got %0d", want.key_index, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[4] != want.pressed) begin
          $error("pressed: expected %0d, got %0d", want.pressed, out_tdata[4]);
          mismatches++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("button_scan_holdoff_debounce_core verification failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin : stimulus
    event_t           ev;
    row_t             row;
    logic             op;
    logic [BTN_W-1:0] btn;
    logic             lvl;
    logic [BTN_W-1:0] hot_btn;
    logic [HOLD_W-1:0] hold;
    int               tick_pct;

    hang_cycles    = 0;
    stall_left     = 0;
    words_sent     = 0;
    events_seen    = 0;
    cfg_writes     = 0;
    mismatches     = 0;
    in_idle_odds   = 4;
    out_stall_odds = 5;
    now_ms         = '0;
    key_levels     = '0;
    lockout_ms     = HOLDOFF_RESET;
    foreach (change_stamp[k]) change_stamp[k] = '0;

    // Hold reset at start-up, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = PLAN[r];
      if (row.kind == ROW_CFG) begin
        set_lockout(row.hold);
      end else begin
        for (int n = 0; n < int'(row.reps); n++) begin
          idle_burst();
          push_word(row.op, row.btn, row.lvl);
          if (debounce_step(row.op, row.btn, row.lvl, ev) && row.chk == CHK_MODEL)
            pending_events.push_back(ev);
          if (row.chk == CHK_EVENT)
            pending_events.push_back(event_t'{key_index: row.key, pressed: row.pr});
        end
      end
    end

    // Random phases, each with its own lockout and idling mix
    for (int p = 0; p < PHASES; p++) begin
      hold = (p == 8) ? HOLD_W'($urandom_range(0, 31)) : PHASE_HOLD[p];
      set_lockout(hold);
      if (p == 5 || p == PHASES - 1) begin
        in_idle_odds   = 0;
        out_stall_odds = 0;
      end else begin
        in_idle_odds   = $urandom_range(2, 8);
        out_stall_odds = $urandom_range(2, 8);
      end
      hot_btn  = BTN_W'($urandom_range(0, KEYS - 1));
      tick_pct = (hold > 16) ? 60 : $urandom_range(20, 45);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          op = OP_TICK;
          btn = BTN_W'($urandom_range(0, 15));
          lvl = 1'($urandom_range(0, 1));
        end else begin
          // Mostly bounce around one button, with a toggle bias to force changes
          op  = OP_SAMPLE;
          btn = ($urandom_range(0, 1) == 0) ? hot_btn : BTN_W'($urandom_range(0, 15));
          lvl = ($urandom_range(0, 9) < 7) ? ~key_levels[btn] : 1'($urandom_range(0, 1));
        end
        idle_burst();
        push_word(op, btn, lvl);
        if (debounce_step(op, btn, lvl, ev)) pending_events.push_back(ev);
      end
    end

    // Let the last events come out, then wait for strays
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d words, %0d key events, %0d lockout settings, ending at %0d ms.",
             words_sent, events_seen, cfg_writes, now_ms);
    if (mismatches == 0) begin
      $display("button_scan_holdoff_debounce_core verification clean");
    end else begin
      $display("button_scan_holdoff_debounce_core verification failed");
    end
    $finish;
  end

endmodule

/* button_scan_holdoff_debounce_core.f */
rtl/bshd_pkg.sv
rtl/bshd_front.sv
rtl/bshd_queue.sv
rtl/bshd_back.sv
rtl/button_scan_holdoff_debounce_core.sv
tb/tb_top.sv
